// ===== src/spsis_pkg.sv =====
// ----------------------------------------------------------------------------
// spsis_pkg: shared types of the sorted point store
// Item kind codes and the status group that the sequencer reports upward.
// ----------------------------------------------------------------------------
`default_nettype none

package spsis_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

`default_nettype wire

// ===== src/spsis_store.sv =====
// ----------------------------------------------------------------------------
// spsis_store: point memory
// One write port for x and y, read port A for x and y, read port B for x only.
// Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spsis_store #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32,
    localparam int ADDR_W    = $clog2(CAPACITY)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic signed [VALUE_BITS-1:0] wr_x,
    input  wire logic signed [VALUE_BITS-1:0] wr_y,
    input  wire logic                         rd_en_a,
    input  wire logic [ADDR_W-1:0]            rd_addr_a,
    input  wire logic                         rd_en_b,
    input  wire logic [ADDR_W-1:0]            rd_addr_b,
    output logic signed [VALUE_BITS-1:0]      rd_x_a,
    output logic signed [VALUE_BITS-1:0]      rd_y_a,
    output logic signed [VALUE_BITS-1:0]      rd_x_b
);

    logic [VALUE_BITS-1:0] x_mem [CAPACITY];
    logic [VALUE_BITS-1:0] y_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        if (rd_en_a)
        begin
            rd_x_a <= x_mem[rd_addr_a];
            rd_y_a <= y_mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_x_b <= x_mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== src/spsis_seq.sv =====
// ----------------------------------------------------------------------------
// spsis_seq: sequencer of the sorted point store
// Runs appends, reads and the two binary searches through one compare unit,
// keeps the fill count and the running x and y extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module spsis_seq
    import spsis_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32,
    localparam int ADDR_W    = $clog2(CAPACITY),
    localparam int IDX_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [1:0]                   kind,
    input  wire logic signed [VALUE_BITS-1:0] point_x,
    input  wire logic signed [VALUE_BITS-1:0] point_y,
    input  wire logic signed [VALUE_BITS-1:0] lower_bound,
    input  wire logic signed [VALUE_BITS-1:0] upper_bound,
    input  wire logic [ADDR_W-1:0]            read_index,
    input  wire logic                         out_free,
    output seq_status_t                       status,
    output logic                              wr_en,
    output logic [ADDR_W-1:0]                 wr_addr,
    output logic signed [VALUE_BITS-1:0]      wr_x,
    output logic signed [VALUE_BITS-1:0]      wr_y,
    output logic                              rd_en_a,
    output logic [ADDR_W-1:0]                 rd_addr_a,
    output logic                              rd_en_b,
    output logic [ADDR_W-1:0]                 rd_addr_b,
    input  wire logic signed [VALUE_BITS-1:0] rd_x_a,
    input  wire logic signed [VALUE_BITS-1:0] rd_y_a,
    input  wire logic signed [VALUE_BITS-1:0] rd_x_b,
    output logic [IDX_W-1:0]                  lower_index,
    output logic [IDX_W-1:0]                  upper_index,
    output logic signed [VALUE_BITS-1:0]      read_x,
    output logic signed [VALUE_BITS-1:0]      read_y,
    output logic signed [VALUE_BITS-1:0]      least_x,
    output logic signed [VALUE_BITS-1:0]      greatest_x,
    output logic signed [VALUE_BITS-1:0]      least_y,
    output logic signed [VALUE_BITS-1:0]      greatest_y,
    output logic [IDX_W-1:0]                  stored_count,
    output logic                              dropped
);

    // Search window bounds are signed so that an empty window reads as right below left.
    localparam int SW = IDX_W + 1;
    localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] MOST_NEG = ~MOST_POS;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_READ    = 5'b00010,
        S_PROBE   = 5'b00100,
        S_COMPARE = 5'b01000,
        S_FINISH  = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               count_reg, count_next;
    logic signed [VALUE_BITS-1:0]   min_x_reg, min_x_next;
    logic signed [VALUE_BITS-1:0]   max_x_reg, max_x_next;
    logic signed [VALUE_BITS-1:0]   min_y_reg, min_y_next;
    logic signed [VALUE_BITS-1:0]   max_y_reg, max_y_next;
    logic                           phase_reg, phase_next;

    logic signed [SW-1:0]           left_reg, left_next;
    logic signed [SW-1:0]           right_reg, right_next;
    logic [ADDR_W-1:0]              mid_reg, mid_next;
    logic signed [VALUE_BITS-1:0]   lower_bnd_reg, lower_bnd_next;
    logic signed [VALUE_BITS-1:0]   upper_bnd_reg, upper_bnd_next;
    logic [ADDR_W-1:0]              read_idx_reg, read_idx_next;
    logic [IDX_W-1:0]               lower_idx_reg, lower_idx_next;
    logic [IDX_W-1:0]               upper_idx_reg, upper_idx_next;
    logic signed [VALUE_BITS-1:0]   read_x_reg, read_x_next;
    logic signed [VALUE_BITS-1:0]   read_y_reg, read_y_next;
    logic                           dropped_reg, dropped_next;

    kind_t                          kind_in;
    logic                           start;
    logic                           full;
    logic signed [SW:0]             probe_sum;
    logic [ADDR_W-1:0]              mid_c;
    logic                           loop_run;
    logic                           mid_last;
    logic                           probe_issue;
    logic signed [VALUE_BITS-1:0]   key;
    logic                           below_a;
    logic                           above_b;
    logic                           above_a;
    logic signed [SW-1:0]           right_init;

    assign kind_in     = kind_t'(kind);
    assign start       = in_valid && (state_reg == S_IDLE);
    assign full        = (count_reg == IDX_W'(CAPACITY));
    assign probe_sum   = {left_reg[SW-1], left_reg} + {right_reg[SW-1], right_reg};
    assign mid_c       = probe_sum[ADDR_W:1];
    assign loop_run    = (left_reg <= right_reg);
    assign mid_last    = ((IDX_W'(mid_c) + IDX_W'(1)) == count_reg);
    assign probe_issue = (state_reg == S_PROBE) && loop_run && !mid_last;
    assign right_init  = SW'(count_reg) - SW'(1);

    // The shared compare unit: the bound under search against two neighboring x values.
    assign key     = phase_reg ? upper_bnd_reg : lower_bnd_reg;
    assign below_a = (rd_x_a < key);
    assign above_b = (key < rd_x_b);
    assign above_a = (rd_x_a > key);

    assign wr_en     = start && (kind_in == KIND_APPEND) && !full;
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign wr_x      = point_x;
    assign wr_y      = point_y;
    assign rd_en_a   = (start && (kind_in == KIND_READ)) || probe_issue;
    assign rd_addr_a = (state_reg == S_IDLE) ? read_index : mid_c;
    assign rd_en_b   = probe_issue;
    assign rd_addr_b = mid_c + ADDR_W'(1);

    always_comb
    begin
        logic             bound_done;
        logic [IDX_W-1:0] answer;

        bound_done     = 1'b0;
        answer         = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        phase_next     = phase_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        lower_bnd_next = lower_bnd_reg;
        upper_bnd_next = upper_bnd_reg;
        read_idx_next  = read_idx_reg;
        lower_idx_next = lower_idx_reg;
        upper_idx_next = upper_idx_reg;
        read_x_next    = read_x_reg;
        read_y_next    = read_y_reg;
        dropped_next   = dropped_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lower_idx_next = '0;
                    upper_idx_next = '0;
                    read_x_next    = '0;
                    read_y_next    = '0;
                    dropped_next   = 1'b0;
                    unique case (kind_in)
                        KIND_APPEND:
                        begin
                            if (full)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + IDX_W'(1);
                                if (point_x > max_x_reg) max_x_next = point_x;
                                if (point_x < min_x_reg) min_x_next = point_x;
                                if (point_y > max_y_reg) max_y_next = point_y;
                                if (point_y < min_y_reg) min_y_next = point_y;
                            end
                            state_next = S_FINISH;
                        end
                        KIND_SEARCH:
                        begin
                            lower_bnd_next = lower_bound;
                            upper_bnd_next = upper_bound;
                            phase_next     = 1'b0;
                            left_next      = '0;
                            right_next     = right_init;
                            state_next     = S_PROBE;
                        end
                        KIND_READ:
                        begin
                            read_idx_next = read_index;
                            state_next    = S_READ;
                        end
                        KIND_NONE:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (IDX_W'(read_idx_reg) < count_reg)
                begin
                    read_x_next = rd_x_a;
                    read_y_next = rd_y_a;
                end
                state_next = S_FINISH;
            end
            S_PROBE:
            begin
                if (!loop_run)
                begin
                    bound_done = 1'b1;
                    answer     = '0;
                end
                else if (mid_last)
                begin
                    bound_done = 1'b1;
                    answer     = count_reg;
                end
                else
                begin
                    mid_next   = mid_c;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (below_a && above_b)
                begin
                    bound_done = 1'b1;
                    answer     = IDX_W'(mid_reg) + IDX_W'(1);
                end
                else if (above_a)
                begin
                    right_next = SW'(mid_reg) - SW'(1);
                    state_next = S_PROBE;
                end
                else
                begin
                    left_next  = SW'(mid_reg) + SW'(1);
                    state_next = S_PROBE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished lower search restarts the window for the upper bound.
        if (bound_done)
        begin
            if (!phase_reg)
            begin
                lower_idx_next = answer;
                phase_next     = 1'b1;
                left_next      = '0;
                right_next     = right_init;
                state_next     = S_PROBE;
            end
            else
            begin
                upper_idx_next = answer;
                state_next     = S_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            min_x_reg <= MOST_POS;
            max_x_reg <= MOST_NEG;
            min_y_reg <= MOST_POS;
            max_y_reg <= MOST_NEG;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        mid_reg       <= mid_next;
        lower_bnd_reg <= lower_bnd_next;
        upper_bnd_reg <= upper_bnd_next;
        read_idx_reg  <= read_idx_next;
        lower_idx_reg <= lower_idx_next;
        upper_idx_reg <= upper_idx_next;
        read_x_reg    <= read_x_next;
        read_y_reg    <= read_y_next;
        dropped_reg   <= dropped_next;
    end

    assign status.idle  = (state_reg == S_IDLE);
    assign status.done  = (state_reg == S_FINISH);
    assign lower_index  = lower_idx_reg;
    assign upper_index  = upper_idx_reg;
    assign read_x       = read_x_reg;
    assign read_y       = read_y_reg;
    assign least_x      = min_x_reg;
    assign greatest_x   = max_x_reg;
    assign least_y      = min_y_reg;
    assign greatest_y   = max_y_reg;
    assign stored_count = count_reg;
    assign dropped      = dropped_reg;

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= IDX_W'(CAPACITY)
    ) else $error("fill count beyond capacity");

    a_compare_inside: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPARE) |-> ((IDX_W'(mid_reg) + IDX_W'(1)) < count_reg)
    ) else $error("compare probe reaches past the last stored point");

    a_drop_only_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && dropped_reg) |-> full
    ) else $error("append dropped while store had room");

    a_append_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + IDX_W'(1))
    ) else $error("stored append did not advance the fill count");

endmodule

`default_nettype wire

// ===== src/sorted_point_store_interval_search.sv =====
// ----------------------------------------------------------------------------
// sorted_point_store_interval_search: sorted point store with interval search
// Appends ascending x/y points, tracks x and y extremes, reads points back and
// binary-searches a lower and an upper x bound for the enclosing interval.
//
//   channel   handshake           payload
//   input     in_valid/in_stall   kind, point_x, point_y, lower_bound,
//                                 upper_bound, read_index
//   output    out_valid/out_stall lower_index, upper_index, read_x, read_y,
//                                 least_x, greatest_x, least_y, greatest_y,
//                                 stored_count, dropped
//
// An append or an unused kind goes from idle straight to the finish state, a read
// passes through a read state first. A search runs a binary search for each bound:
// each probe takes a probe state that issues the memory read and a compare state,
// and a bound that no compare settles ends on one more probe.
// One item is in work at a time; in_stall is high from acceptance until its
// item has moved into the output register.
// Reset clears the fill count and sets the trackers to their extreme values.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_point_store_interval_search
    import spsis_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32,
    localparam int ADDR_W    = $clog2(CAPACITY),
    localparam int IDX_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   kind,
    input  wire logic signed [VALUE_BITS-1:0] point_x,
    input  wire logic signed [VALUE_BITS-1:0] point_y,
    input  wire logic signed [VALUE_BITS-1:0] lower_bound,
    input  wire logic signed [VALUE_BITS-1:0] upper_bound,
    input  wire logic [ADDR_W-1:0]            read_index,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [IDX_W-1:0]                  lower_index,
    output logic [IDX_W-1:0]                  upper_index,
    output logic signed [VALUE_BITS-1:0]      read_x,
    output logic signed [VALUE_BITS-1:0]      read_y,
    output logic signed [VALUE_BITS-1:0]      least_x,
    output logic signed [VALUE_BITS-1:0]      greatest_x,
    output logic signed [VALUE_BITS-1:0]      least_y,
    output logic signed [VALUE_BITS-1:0]      greatest_y,
    output logic [IDX_W-1:0]                  stored_count,
    output logic                              dropped
);

    seq_status_t                  status;
    logic                         out_free;
    logic                         load;
    logic                         out_valid_reg, out_valid_next;

    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic signed [VALUE_BITS-1:0] wr_x;
    logic signed [VALUE_BITS-1:0] wr_y;
    logic                         rd_en_a;
    logic [ADDR_W-1:0]            rd_addr_a;
    logic                         rd_en_b;
    logic [ADDR_W-1:0]            rd_addr_b;
    logic signed [VALUE_BITS-1:0] rd_x_a;
    logic signed [VALUE_BITS-1:0] rd_y_a;
    logic signed [VALUE_BITS-1:0] rd_x_b;

    logic [IDX_W-1:0]             s_lower_index;
    logic [IDX_W-1:0]             s_upper_index;
    logic signed [VALUE_BITS-1:0] s_read_x;
    logic signed [VALUE_BITS-1:0] s_read_y;
    logic signed [VALUE_BITS-1:0] s_least_x;
    logic signed [VALUE_BITS-1:0] s_greatest_x;
    logic signed [VALUE_BITS-1:0] s_least_y;
    logic signed [VALUE_BITS-1:0] s_greatest_y;
    logic [IDX_W-1:0]             s_stored_count;
    logic                         s_dropped;

    logic [IDX_W-1:0]             lower_index_reg;
    logic [IDX_W-1:0]             upper_index_reg;
    logic signed [VALUE_BITS-1:0] read_x_reg;
    logic signed [VALUE_BITS-1:0] read_y_reg;
    logic signed [VALUE_BITS-1:0] least_x_reg;
    logic signed [VALUE_BITS-1:0] greatest_x_reg;
    logic signed [VALUE_BITS-1:0] least_y_reg;
    logic signed [VALUE_BITS-1:0] greatest_y_reg;
    logic [IDX_W-1:0]             stored_count_reg;
    logic                         dropped_reg;

    spsis_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (wr_x),
        .wr_y      (wr_y),
        .rd_en_a   (rd_en_a),
        .rd_addr_a (rd_addr_a),
        .rd_en_b   (rd_en_b),
        .rd_addr_b (rd_addr_b),
        .rd_x_a    (rd_x_a),
        .rd_y_a    (rd_y_a),
        .rd_x_b    (rd_x_b)
    );

    spsis_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .kind         (kind),
        .point_x      (point_x),
        .point_y      (point_y),
        .lower_bound  (lower_bound),
        .upper_bound  (upper_bound),
        .read_index   (read_index),
        .out_free     (out_free),
        .status       (status),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_x         (wr_x),
        .wr_y         (wr_y),
        .rd_en_a      (rd_en_a),
        .rd_addr_a    (rd_addr_a),
        .rd_en_b      (rd_en_b),
        .rd_addr_b    (rd_addr_b),
        .rd_x_a       (rd_x_a),
        .rd_y_a       (rd_y_a),
        .rd_x_b       (rd_x_b),
        .lower_index  (s_lower_index),
        .upper_index  (s_upper_index),
        .read_x       (s_read_x),
        .read_y       (s_read_y),
        .least_x      (s_least_x),
        .greatest_x   (s_greatest_x),
        .least_y      (s_least_y),
        .greatest_y   (s_greatest_y),
        .stored_count (s_stored_count),
        .dropped      (s_dropped)
    );

    // The output register takes a new item when it is empty or being drained.
    assign out_free       = !out_valid_reg || !out_stall;
    assign load           = status.done && out_free;
    assign out_valid_next = load || (out_valid_reg && out_stall);
    assign in_stall       = !status.idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lower_index_reg  <= s_lower_index;
            upper_index_reg  <= s_upper_index;
            read_x_reg       <= s_read_x;
            read_y_reg       <= s_read_y;
            least_x_reg      <= s_least_x;
            greatest_x_reg   <= s_greatest_x;
            least_y_reg      <= s_least_y;
            greatest_y_reg   <= s_greatest_y;
            stored_count_reg <= s_stored_count;
            dropped_reg      <= s_dropped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lower_index  = lower_index_reg;
    assign upper_index  = upper_index_reg;
    assign read_x       = read_x_reg;
    assign read_y       = read_y_reg;
    assign least_x      = least_x_reg;
    assign greatest_x   = greatest_x_reg;
    assign least_y      = least_y_reg;
    assign greatest_y   = greatest_y_reg;
    assign stored_count = stored_count_reg;
    assign dropped      = dropped_reg;

endmodule

`default_nettype wire
